@@ hw/rtl/nffl_pkg.sv @@
// ----------------------------------------------------------------------------
// nffl_pkg
// shared types, constants and command codes of the next-fit allocator
// ----------------------------------------------------------------------------
package nffl_pkg;

    localparam int ARENA_UNITS = 4096;
    localparam int UNIT_BYTES  = 16;
    localparam int UNIT_SHIFT  = 4;
    localparam int ADDR_W      = 12;
    localparam int SIZE_W      = 13;
    localparam int STEP_W      = 13;
    localparam int REQ_W       = 16;
    localparam int EXT_W       = 14;

    typedef struct packed {
        logic [ADDR_W-1:0] link;
        logic [SIZE_W-1:0] size;
    } t_hdr;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLR,
        CMD_START,
        CMD_A_FIRST,
        CMD_A_NEXT,
        CMD_A_EXACT,
        CMD_A_SPLIT,
        CMD_A_TAIL,
        CMD_A_FAIL,
        CMD_F_NEXT,
        CMD_F_FOUND,
        CMD_F_RDNX,
        CMD_F_WRBP,
        CMD_F_WRP,
        CMD_F_DONE
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic fit;
        logic exact;
        logic stop;
        logic addr_ok;
        logic found;
        logic giveup;
        logic out_busy;
    } t_stat;

endpackage

@@ hw/rtl/next_fit_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// next_fit_free_list_allocator
// next-fit allocator over a 4096-unit arena with headers in on-chip memory
// ----------------------------------------------------------------------------
// an alloc reads the rover header, then one free-list header per walk step,
//   plus a tail write on split; a free of a bad address stops at its first
//   step, else it walks alike, reads the block and next headers, writes two
// throughput: one item at a time, bounded by the header walk
// reset: synchronous; a clearing pass rebuilds the arena while input ready stays low
module next_fit_free_list_allocator import nffl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [REQ_W-1:0]  i_request_bytes,
    input  logic [ADDR_W-1:0] i_free_addr,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_status,
    output logic [ADDR_W-1:0] o_block_addr
);

    t_cmd  cmd;
    t_stat stat;

    nffl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    nffl_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_request_bytes (i_request_bytes),
        .i_free_addr     (i_free_addr),
        .i_out_ready     (i_out_ready),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_block_addr    (o_block_addr)
    );

endmodule

@@ hw/rtl/nffl_ctrl.sv @@
// ----------------------------------------------------------------------------
// nffl_ctrl
// sequencer: clearing pass, list walks and header updates
// ----------------------------------------------------------------------------
module nffl_ctrl import nffl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_CLR    = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_A_FRST = 10'b0000000100,
        S_A_STEP = 10'b0000001000,
        S_A_TAIL = 10'b0000010000,
        S_F_STEP = 10'b0000100000,
        S_F_RDNX = 10'b0001000000,
        S_F_WRBP = 10'b0010000000,
        S_F_WRP  = 10'b0100000000,
        S_SPARE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_CLR: begin
                o_cmd = CMD_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_START;
                    n_state = S_A_FRST;
                end
            end
            S_A_FRST: begin
                o_cmd   = i_stat.is_free ? CMD_NONE : CMD_A_FIRST;
                n_state = i_stat.is_free ? S_F_STEP : S_A_STEP;
            end
            S_A_STEP: begin
                if (!i_stat.out_busy) begin
                    if (i_stat.fit && i_stat.exact) begin
                        o_cmd   = CMD_A_EXACT;
                        n_state = S_IDLE;
                    end else if (i_stat.fit) begin
                        o_cmd   = CMD_A_SPLIT;
                        n_state = S_A_TAIL;
                    end else if (i_stat.stop) begin
                        o_cmd   = CMD_A_FAIL;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd = CMD_A_NEXT;
                    end
                end
            end
            S_A_TAIL: begin
                if (!i_stat.out_busy) begin
                    o_cmd   = CMD_A_TAIL;
                    n_state = S_IDLE;
                end
            end
            S_F_STEP: begin
                if (!i_stat.out_busy) begin
                    if (!i_stat.addr_ok) begin
                        o_cmd   = CMD_F_DONE;
                        n_state = S_IDLE;
                    end else if (i_stat.found) begin
                        o_cmd   = CMD_F_FOUND;
                        n_state = S_F_RDNX;
                    end else if (i_stat.giveup) begin
                        o_cmd   = CMD_F_DONE;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd = CMD_F_NEXT;
                    end
                end
            end
            S_F_RDNX: begin
                o_cmd   = CMD_F_RDNX;
                n_state = S_F_WRBP;
            end
            S_F_WRBP: begin
                o_cmd   = CMD_F_WRBP;
                n_state = S_F_WRP;
            end
            S_F_WRP: begin
                if (!i_stat.out_busy) begin
                    o_cmd   = CMD_F_WRP;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/nffl_dp.sv @@
// ----------------------------------------------------------------------------
// nffl_dp
// header memory, walk registers, fit and insertion checks, result register
// ----------------------------------------------------------------------------
module nffl_dp import nffl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_op,
    input  logic [REQ_W-1:0]  i_request_bytes,
    input  logic [ADDR_W-1:0] i_free_addr,
    input  logic              i_out_ready,
    output t_stat             o_stat,
    output logic              o_out_valid,
    output logic              o_status,
    output logic [ADDR_W-1:0] o_block_addr
);

    t_hdr mem [ARENA_UNITS];

    t_hdr              r_rdata;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    t_hdr              wr_data;

    logic [ADDR_W-1:0] r_clr;
    logic              r_op, r_addr_ok;
    logic [SIZE_W-1:0] r_need;
    logic [ADDR_W-1:0] r_bp, r_rover, r_prev, r_p, r_nx, r_blk;
    logic [SIZE_W-1:0] r_prev_size, r_psize;
    logic [STEP_W-1:0] r_steps;
    t_hdr              r_bhdr, r_nb;
    logic              r_out_valid, r_status;
    logic [ADDR_W-1:0] r_block;

    logic [REQ_W:0]    req_sum;
    logic [SIZE_W-1:0] need_in;
    logic [SIZE_W-1:0] rest;
    logic [EXT_W-1:0]  p_end;
    logic              merge_hi, merge_lo;
    t_hdr              nb, clr_hdr;
    logic              load_out, out_stat;
    logic [ADDR_W-1:0] out_blk;

    assign req_sum = {1'b0, i_request_bytes} + (REQ_W+1)'(UNIT_BYTES - 1);
    assign need_in = SIZE_W'(req_sum >> UNIT_SHIFT) + SIZE_W'(1);
    assign rest    = r_rdata.size - r_need;
    assign p_end   = EXT_W'(r_p) + EXT_W'(r_rdata.size);

    assign merge_hi = (EXT_W'(r_bp) + EXT_W'(r_bhdr.size)) == EXT_W'(r_nx);
    assign merge_lo = (EXT_W'(r_p) + EXT_W'(r_psize)) == EXT_W'(r_bp);

    always_comb begin
        if (merge_hi) begin
            nb.link = r_rdata.link;
            nb.size = r_bhdr.size + r_rdata.size;
        end else begin
            nb.link = r_nx;
            nb.size = r_bhdr.size;
        end
    end

    always_comb begin
        clr_hdr = '0;
        if (r_clr == ADDR_W'(0)) begin
            clr_hdr.link = ADDR_W'(1);
        end else if (r_clr == ADDR_W'(1)) begin
            clr_hdr.size = SIZE_W'(ARENA_UNITS - 1);
        end
    end

    always_comb begin
        o_stat.clr_last = (r_clr == '1);
        o_stat.is_free  = r_op;
        o_stat.fit      = (r_rdata.size >= r_need) && (p_end <= EXT_W'(ARENA_UNITS));
        o_stat.exact    = (r_rdata.size == r_need);
        o_stat.stop     = (r_p == r_rover) || (r_steps == STEP_W'(ARENA_UNITS));
        o_stat.addr_ok  = r_addr_ok;
        o_stat.found    = ((r_bp > r_p) && (r_bp < r_rdata.link)) ||
                          ((r_p >= r_rdata.link) && ((r_bp > r_p) || (r_bp < r_rdata.link)));
        o_stat.giveup   = (r_steps == STEP_W'(ARENA_UNITS));
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    always_comb begin
        rd_en    = 1'b0;
        rd_addr  = r_rdata.link;
        wr_en    = 1'b0;
        wr_addr  = r_p;
        wr_data  = r_rdata;
        load_out = 1'b0;
        out_stat = 1'b0;
        out_blk  = '0;
        unique case (i_cmd)
            CMD_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = clr_hdr;
            end
            CMD_START: begin
                rd_en   = 1'b1;
                rd_addr = r_rover;
            end
            CMD_A_FIRST, CMD_A_NEXT, CMD_F_NEXT: begin
                rd_en = 1'b1;
            end
            CMD_A_EXACT: begin
                wr_en        = 1'b1;
                wr_addr      = r_prev;
                wr_data.link = r_rdata.link;
                wr_data.size = r_prev_size;
                load_out     = 1'b1;
                out_blk      = r_p + ADDR_W'(1);
            end
            CMD_A_SPLIT: begin
                wr_en        = 1'b1;
                wr_addr      = r_p;
                wr_data.size = rest;
                rd_en        = 1'b1;
                rd_addr      = r_p + ADDR_W'(rest);
            end
            CMD_A_TAIL: begin
                wr_en        = 1'b1;
                wr_addr      = r_blk;
                wr_data.size = r_need;
                load_out     = 1'b1;
                out_blk      = r_blk + ADDR_W'(1);
            end
            CMD_A_FAIL: begin
                load_out = 1'b1;
                out_stat = 1'b1;
            end
            CMD_F_FOUND: begin
                rd_en   = 1'b1;
                rd_addr = r_bp;
            end
            CMD_F_RDNX: begin
                rd_en   = 1'b1;
                rd_addr = r_nx;
            end
            CMD_F_WRBP: begin
                wr_en   = 1'b1;
                wr_addr = r_bp;
                wr_data = nb;
            end
            CMD_F_WRP: begin
                wr_en   = 1'b1;
                wr_addr = r_p;
                if (merge_lo) begin
                    wr_data.link = r_nb.link;
                    wr_data.size = r_psize + r_nb.size;
                end else begin
                    wr_data.link = r_bp;
                    wr_data.size = r_psize;
                end
                load_out = 1'b1;
            end
            CMD_F_DONE: begin
                load_out = 1'b1;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_START: begin
                r_op      <= i_op;
                r_need    <= need_in;
                r_bp      <= i_free_addr - ADDR_W'(1);
                r_addr_ok <= (i_free_addr >= ADDR_W'(2));
                r_prev    <= r_rover;
                r_p       <= r_rover;
                r_steps   <= '0;
            end
            CMD_A_FIRST: begin
                r_prev_size <= r_rdata.size;
                r_p         <= r_rdata.link;
            end
            CMD_A_NEXT: begin
                r_prev      <= r_p;
                r_prev_size <= r_rdata.size;
                r_p         <= r_rdata.link;
                r_steps     <= r_steps + STEP_W'(1);
            end
            CMD_A_SPLIT: begin
                r_blk <= r_p + ADDR_W'(rest);
            end
            CMD_F_NEXT: begin
                r_p     <= r_rdata.link;
                r_steps <= r_steps + STEP_W'(1);
            end
            CMD_F_FOUND: begin
                r_psize <= r_rdata.size;
                r_nx    <= r_rdata.link;
            end
            CMD_F_RDNX: begin
                r_bhdr <= r_rdata;
            end
            CMD_F_WRBP: begin
                r_nb <= nb;
            end
            default: begin
                r_blk <= r_blk;
            end
        endcase
        if (load_out) begin
            r_status <= out_stat;
            r_block  <= out_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_rover     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd == CMD_CLR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (i_cmd == CMD_A_EXACT || i_cmd == CMD_A_SPLIT) begin
                r_rover <= r_prev;
            end else if (i_cmd == CMD_F_WRP) begin
                r_rover <= r_p;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_block_addr = r_block;

`ifndef ASSERT_OFF
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_CLR) |-> !r_out_valid)
        else $error("result pending during clearing pass");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !(r_out_valid && !i_out_ready))
        else $error("result register overwritten before transfer");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status) |-> (r_block == '0))
        else $error("failed allocation returns nonzero address");
    a_rover_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_A_FAIL) |=> $stable(r_rover))
        else $error("rover moved on failed allocation");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// next-fit allocator check: directed and random allocate/free traffic, every
// result compared against an in-bench model of the free list and rover
// ----------------------------------------------------------------------------
module testbench;
    import nffl_pkg::*;

    typedef struct {
        logic              op;
        logic [REQ_W-1:0]  bytes;
        logic [ADDR_W-1:0] faddr;
    } t_req;

    typedef struct {
        logic              status;
        logic [ADDR_W-1:0] addr;
    } t_grant;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_op = 1'b0;
    logic [REQ_W-1:0]  i_request_bytes = '0;
    logic [ADDR_W-1:0] i_free_addr = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_status;
    logic [ADDR_W-1:0] o_block_addr;

    next_fit_free_list_allocator u_top (.*);

    always #5 i_clk = ~i_clk;

    int unsigned hlink [ARENA_UNITS];
    int unsigned hsize [ARENA_UNITS];
    int unsigned rov;

    t_req   pending_reqs[$];
    t_grant grants_due[$];
    int     errors = 0;
    int     sent = 0;
    int     n_alloc_ok = 0, n_alloc_fail = 0, n_free = 0;
    logic   gen_done = 1'b0;
    logic   in_fired = 1'b0;

    function automatic t_grant model_alloc(int unsigned bytes);
        longint unsigned need, sz;
        int unsigned prev, p, blk, rest;
        t_grant g;
        need = (longint'(bytes) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
        prev = rov;
        p = hlink[prev];
        g.status = 1'b1;
        g.addr = '0;
        for (int s = 0; s <= ARENA_UNITS; s++) begin
            sz = hsize[p];
            if (sz >= need && longint'(p) + sz <= ARENA_UNITS) begin
                blk = p;
                if (sz == need) begin
                    hlink[prev] = hlink[p];
                end else begin
                    rest = 32'(sz - need);
                    hsize[p] = rest;
                    blk = p + rest;
                    hsize[blk] = 32'(need);
                end
                rov = prev;
                g.status = 1'b0;
                g.addr = ADDR_W'(blk + 1);
                return g;
            end
            if (p == rov) break;
            prev = p;
            p = hlink[p];
        end
        return g;
    endfunction

    function automatic void model_free(int unsigned addr);
        int unsigned bp, p, nx;
        bit found;
        found = 0;
        if (addr < 2 || addr > ARENA_UNITS) return;
        bp = addr - 1;
        p = rov;
        for (int s = 0; s <= ARENA_UNITS; s++) begin
            nx = hlink[p];
            if (bp > p && bp < nx) begin
                found = 1;
                break;
            end
            if (p >= nx && (bp > p || bp < nx)) begin
                found = 1;
                break;
            end
            p = nx;
        end
        if (!found) return;
        nx = hlink[p];
        if (longint'(bp) + hsize[bp] == nx) begin
            hsize[bp] += hsize[nx];
            hlink[bp] = hlink[nx];
        end else begin
            hlink[bp] = nx;
        end
        if (longint'(p) + hsize[p] == bp) begin
            hsize[p] += hsize[bp];
            hlink[p] = hlink[bp];
        end else begin
            hlink[p] = bp;
        end
        rov = p;
    endfunction

    function automatic t_grant issue(logic op, int unsigned bytes, int unsigned faddr);
        t_req r;
        t_grant g;
        r.op = op;
        r.bytes = (op == OP_ALLOC) ? REQ_W'(bytes) : REQ_W'($urandom);
        r.faddr = (op == OP_FREE) ? ADDR_W'(faddr) : ADDR_W'($urandom);
        if (op == OP_ALLOC) begin
            g = model_alloc(r.bytes);
            if (g.status) n_alloc_fail++;
            else n_alloc_ok++;
        end else begin
            model_free(r.faddr);
            g.status = 1'b0;
            g.addr = '0;
            n_free++;
        end
        pending_reqs.push_back(r);
        grants_due.push_back(g);
        return g;
    endfunction

    // stimulus generation, model run in the same order as the transfers
    initial begin
        logic [ADDR_W-1:0] live[$];
        logic [ADDR_W-1:0] last_freed;
        t_grant g;
        int r, k, sz;
        for (int i = 0; i < ARENA_UNITS; i++) begin
            hlink[i] = 0;
            hsize[i] = 0;
        end
        hlink[0] = 1;
        hsize[1] = ARENA_UNITS - 1;
        rov = 0;
        last_freed = '0;

        g = issue(OP_FREE, 0, 0);
        g = issue(OP_FREE, 0, 1);
        g = issue(OP_ALLOC, 65535, 0);
        g = issue(OP_ALLOC, 65520, 0);
        g = issue(OP_ALLOC, 0, 0);
        if (!g.status) live.push_back(g.addr);
        g = issue(OP_ALLOC, 1, 0);    if (!g.status) live.push_back(g.addr);
        g = issue(OP_ALLOC, 16, 0);   if (!g.status) live.push_back(g.addr);
        g = issue(OP_ALLOC, 17, 0);   if (!g.status) live.push_back(g.addr);
        g = issue(OP_ALLOC, 1000, 0); if (!g.status) live.push_back(g.addr);
        g = issue(OP_FREE, 0, 4095);
        g = issue(OP_FREE, 0, live[1]);
        g = issue(OP_FREE, 0, live[1]);
        g = issue(OP_FREE, 0, live[3]);
        g = issue(OP_FREE, 0, live[2]);
        g = issue(OP_FREE, 0, live[0]);
        g = issue(OP_FREE, 0, live[4]);
        live.delete();
        g = issue(OP_ALLOC, 65504, 0);
        if (!g.status) live.push_back(g.addr);
        g = issue(OP_ALLOC, 0, 0);
        if (!g.status) live.push_back(g.addr);
        g = issue(OP_ALLOC, 16, 0);
        while (live.size() > 0) begin
            g = issue(OP_FREE, 0, live.pop_back());
        end

        for (int n = 0; n < 1530; n++) begin
            r = $urandom_range(99);
            if (r < 50 || live.size() == 0) begin
                k = $urandom_range(99);
                if (k < 70) sz = $urandom_range(400);
                else if (k < 90) sz = $urandom_range(4000);
                else if (k < 98) sz = $urandom_range(65535);
                else sz = 65535;
                g = issue(OP_ALLOC, sz, 0);
                if (!g.status) live.push_back(g.addr);
            end else if (r < 95) begin
                k = $urandom_range(live.size() - 1);
                last_freed = live[k];
                live.delete(k);
                g = issue(OP_FREE, 0, last_freed);
            end else if (r < 97) begin
                g = issue(OP_FREE, 0, last_freed);
            end else if (r < 99) begin
                g = issue(OP_FREE, 0, $urandom_range(1));
            end else begin
                g = issue(OP_FREE, 0, $urandom_range(4095));
            end
        end
        gen_done = 1'b1;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic bit idle_now();
        if (sent >= 600 && sent < 900) return 0;
        return $urandom_range(99) < 25;
    endfunction

    always @(posedge i_clk) begin
        in_fired <= i_in_valid && o_in_ready;
    end

    // driver
    always @(negedge i_clk) begin
        t_req r;
        if (i_rst_n && gen_done && (!i_in_valid || in_fired)) begin
            if (pending_reqs.size() > 0 && !idle_now()) begin
                r = pending_reqs.pop_front();
                i_op <= r.op;
                i_request_bytes <= r.bytes;
                i_free_addr <= r.faddr;
                i_in_valid <= 1'b1;
                sent <= sent + 1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && !idle_now();
    end

    // monitor
    always @(posedge i_clk) begin
        t_grant g;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grants_due.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                g = grants_due.pop_front();
                if (o_status !== g.status) begin
                    $error("status: expected %0d, actual %0d", g.status, o_status);
                    errors++;
                end
                if (o_block_addr !== g.addr) begin
                    $error("block_addr: expected %0d, actual %0d", g.addr, o_block_addr);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (gen_done);
        wait (pending_reqs.size() == 0 && grants_due.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("run covered %0d allocations (%0d refused) and %0d frees",
                 n_alloc_ok + n_alloc_fail, n_alloc_fail, n_free);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #300ms;
        $display("timeout with %0d results outstanding", grants_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
